@@ hdl/dfls_pkg.sv @@
// Types and constants shared by the distance field level search blocks.
// No dependencies.
package dfls_pkg;
  localparam int NUM_LAYERS = 6;
  localparam int FRAC_BITS = 16;
  localparam int LVL_W = FRAC_BITS + 1;
  localparam int DST_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_DESIRED = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LAYERS = 3'd7;

  typedef struct packed {
    logic [7:0] start_level;
    logic signed [DST_W-1:0] layer_dist_0;
    logic signed [DST_W-1:0] layer_dist_1;
    logic signed [DST_W-1:0] layer_dist_2;
    logic signed [DST_W-1:0] layer_dist_3;
    logic signed [DST_W-1:0] layer_dist_4;
    logic signed [DST_W-1:0] layer_dist_5;
  } dfls_in_t;

  typedef struct packed {
    logic [LVL_W-1:0] level_value;
    logic [7:0] level_index;
    logic found;
  } dfls_out_t;

  // queue word: clamped start, denominator, distances
  typedef struct packed {
    logic [7:0] start;
    logic [7:0] denom;
    logic signed [DST_W-1:0] dist0;
    logic signed [DST_W-1:0] dist1;
    logic signed [DST_W-1:0] dist2;
    logic signed [DST_W-1:0] dist3;
    logic signed [DST_W-1:0] dist4;
    logic signed [DST_W-1:0] dist5;
  } dfls_job_t;
endpackage

@@ hdl/dfls_front.sv @@
// Front: takes commands, clamps start level, pushes jobs to a two-entry queue.
// Depends on dfls_pkg.
module dfls_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  dfls_pkg::dfls_in_t   in_i,
  input  logic [8:0]           levels_i,
  input  logic                 pop_i,
  output logic                 job_valid_o,
  output dfls_pkg::dfls_job_t  job_o
);
  import dfls_pkg::*;

  dfls_job_t q_q [2];
  dfls_job_t job_d;
  logic [1:0] cnt_q, cnt_d;
  logic rd_q, rd_d, wr_q, wr_d;
  logic push;
  logic [8:0] lv;
  logic [7:0] dn;

  assign busy = (cnt_q == 2'd2);
  assign push = start && !busy;
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o = q_q[rd_q];

  always_comb begin
    lv = levels_i;
    if (lv < 9'd2) lv = 9'd2;
    if (lv > 9'd256) lv = 9'd256;
    dn = 8'(lv - 9'd1);
    job_d.denom = dn;
    job_d.start = (in_i.start_level > dn) ? dn : in_i.start_level;
    job_d.dist0 = in_i.layer_dist_0;
    job_d.dist1 = in_i.layer_dist_1;
    job_d.dist2 = in_i.layer_dist_2;
    job_d.dist3 = in_i.layer_dist_3;
    job_d.dist4 = in_i.layer_dist_4;
    job_d.dist5 = in_i.layer_dist_5;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop_i};
    rd_d = pop_i ? ~rd_q : rd_q;
    wr_d = push ? ~wr_q : wr_q;
  end

  always_ff @(posedge clk_i) begin
    if (push) q_q[wr_q] <= job_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q <= 1'b0;
      wr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rd_q <= rd_d;
      wr_q <= wr_d;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != 2'd0) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count overflow");
  a_full_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop_i) |=> busy) else $error("full queue lost");
`endif
endmodule

@@ hdl/dfls_back.sv @@
// Back: per job, walks levels downward; per level a small sequencer forms p,
// finds the bracket, and tests the interpolation sign. Depends on dfls_pkg.
module dfls_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  input  dfls_pkg::dfls_job_t  job_i,
  output logic                 pop_o,
  input  logic [dfls_pkg::LVL_W-1:0] lvl_i [dfls_pkg::NUM_LAYERS],
  input  logic [2:0]           layers_i,
  output logic                 res_valid_o,
  output dfls_pkg::dfls_out_t  res_o
);
  import dfls_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_SRCH = 3'd2,
                         S_MUL = 3'd3, S_SUM = 3'd4;
  localparam int DIVW = 8 + FRAC_BITS + 1;
  localparam logic [LVL_W-1:0] ONE = LVL_W'(1) << FRAC_BITS;

  logic [2:0] st_q, st_d;
  dfls_job_t job_q;
  logic [7:0] d_q, d_d;
  logic [DIVW-1:0] num_q, num_d;
  logic [8:0] rem_q, rem_d;
  logic [LVL_W-1:0] p_q, p_d;
  logic [4:0] bit_q, bit_d;
  logic [2:0] k_q, k_d, l0_q, l0_d;
  logic hit_q, hit_d;
  logic signed [LVL_W+1:0] a_q, b_q;
  logic signed [LVL_W+DST_W+1:0] m0_q, m1_q;
  logic same_q, dneg_q;
  logic [2:0] n;
  logic [LVL_W-1:0] c [NUM_LAYERS];
  logic signed [DST_W-1:0] dv [NUM_LAYERS];
  logic [9:0] r2;
  logic [2:0] l0, l1;
  logic pass;
  logic signed [LVL_W+DST_W+2:0] s;
  logic signed [LVL_W+1:0] dl;
  dfls_out_t res_d;
  logic rv_d;

  always_comb begin
    n = layers_i;
    if (n < 3'd2) n = 3'd2;
    if (n > 3'(NUM_LAYERS)) n = 3'(NUM_LAYERS);
    for (int i = 0; i < NUM_LAYERS; i++) c[i] = (lvl_i[i] > ONE) ? ONE : lvl_i[i];
    dv[0] = job_q.dist0; dv[1] = job_q.dist1; dv[2] = job_q.dist2;
    dv[3] = job_q.dist3; dv[4] = job_q.dist4; dv[5] = job_q.dist5;
  end

  always_comb begin
    st_d = st_q; d_d = d_q; num_d = num_q; rem_d = rem_q; p_d = p_q;
    bit_d = bit_q; k_d = k_q; l0_d = l0_q; hit_d = hit_q;
    pop_o = 1'b0; rv_d = 1'b0; res_d = '0;
    r2 = '0; pass = 1'b0; s = '0;
    dl = '0;
    case (st_q)
      S_IDLE: begin
        if (job_valid_i) begin
          pop_o = 1'b1;
          d_d = job_i.start;
          num_d = DIVW'({job_i.start, {FRAC_BITS{1'b0}}}) + DIVW'(job_i.denom >> 1);
          rem_d = '0; p_d = '0; bit_d = 5'(DIVW - 1);
          st_d = S_DIV;
        end
      end
      S_DIV: begin
        r2 = {rem_q, num_q[bit_q]};
        if (r2 >= {2'b0, job_q.denom}) begin
          rem_d = 9'(r2 - {2'b0, job_q.denom});
          if (bit_q < 5'(LVL_W)) p_d[bit_q[$clog2(LVL_W)-1:0]] = 1'b1;
        end else rem_d = r2[8:0];
        if (bit_q == 5'd0) begin
          st_d = S_SRCH; k_d = '0; hit_d = 1'b0;
        end else bit_d = bit_q - 5'd1;
      end
      S_SRCH: begin
        if (!hit_q && (k_q < n - 3'd1) && p_q >= c[k_q] && p_q <= c[k_q + 3'd1]) begin
          hit_d = 1'b1; l0_d = k_q;
        end
        if (k_q >= n - 3'd2) begin
          st_d = S_MUL;
          if (!hit_d) l0_d = (p_q >= c[n - 3'd1]) ? n - 3'd1 : 3'd0;
        end else k_d = k_q + 3'd1;
      end
      S_MUL: st_d = S_SUM;
      S_SUM: begin
        s = (LVL_W+DST_W+3)'(m0_q) + (LVL_W+DST_W+3)'(m1_q);
        dl = a_q + b_q;
        if (same_q || dl == '0) pass = dneg_q;
        else if (dl > 0) pass = (s <= 0);
        else pass = (s >= 0);
        if (pass || d_q == 8'd0) begin
          rv_d = 1'b1;
          res_d.found = pass;
          res_d.level_value = pass ? p_q : '0;
          res_d.level_index = pass ? d_q : '0;
          st_d = S_IDLE;
        end else begin
          d_d = d_q - 8'd1;
          num_d = DIVW'({d_d, {FRAC_BITS{1'b0}}}) + DIVW'(job_q.denom >> 1);
          rem_d = '0; p_d = '0; bit_d = 5'(DIVW - 1);
          st_d = S_DIV;
        end
      end
      default: st_d = S_IDLE;
    endcase
    l0 = l0_d;
    l1 = (l0_d + 3'd1 < n) ? l0_d + 3'd1 : n - 3'd1;
  end

  // registered multiply stage operands
  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && job_valid_i) job_q <= job_i;
    if (st_q == S_SRCH) begin
      a_q <= $signed({2'b0, c[l1]}) - $signed({2'b0, p_q});
      b_q <= $signed({2'b0, p_q}) - $signed({2'b0, c[l0]});
      same_q <= (l0 == l1);
      dneg_q <= (dv[l0] <= 0);
    end
    if (st_q == S_MUL) begin
      m0_q <= a_q * dv[l0];
      m1_q <= b_q * dv[l1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; res_valid_o <= 1'b0; res_o <= '0;
      d_q <= '0; num_q <= '0; rem_q <= '0; p_q <= '0; bit_q <= '0;
      k_q <= '0; l0_q <= '0; hit_q <= 1'b0;
    end else begin
      st_q <= st_d; res_valid_o <= rv_d; res_o <= res_d;
      d_q <= d_d; num_q <= num_d; rem_q <= rem_d; p_q <= p_d; bit_q <= bit_d;
      k_q <= k_d; l0_q <= l0_d; hit_q <= hit_d;
    end
  end

`ifndef SYNTHESIS
  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> st_q == S_IDLE) else $error("result outside idle");
  a_p_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_SRCH |-> p_q <= ONE) else $error("level above one");
  a_nf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.found) |-> res_o.level_index == 8'd0)
    else $error("nonzero index without hit");
`endif
endmodule

@@ hdl/distance_field_level_search_unit.sv @@
// Top level of the distance field level search: config registers, front, back.
// Depends on dfls_pkg, dfls_front, dfls_back.
//
// channel  | ports                         | handshake
// command  | start, busy, in_i             | start && !busy
// result   | res_valid_o, res_o            | strobe, one cycle
// config   | cfg_we_i, cfg_idx_i, cfg_dat_i| write on cfg_we_i
// Per level: restoring division for p, a bracket search over the layers, then a
// multiply and a sign test; levels are walked down from start until a pass or
// level zero. A two-word queue lets commands land while the back works; busy
// rises when it is full. Reset loads the register defaults.
module distance_field_level_search_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  dfls_pkg::dfls_in_t   in_i,
  output logic                 res_valid_o,
  output dfls_pkg::dfls_out_t  res_o,
  input  logic                 cfg_we_i,
  input  logic [dfls_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dfls_pkg::CFG_DAT_W-1:0] cfg_dat_i
);
  import dfls_pkg::*;

  logic [LVL_W-1:0] lvl_q [NUM_LAYERS];
  logic [8:0] levels_q;
  logic [2:0] layers_q;
  logic pop, jv;
  dfls_job_t job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q[0] <= 17'd0; lvl_q[1] <= 17'd13107; lvl_q[2] <= 17'd26214;
      lvl_q[3] <= 17'd39322; lvl_q[4] <= 17'd52429; lvl_q[5] <= 17'd65536;
      levels_q <= 9'd256; layers_q <= 3'd6;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_DESIRED) levels_q <= cfg_dat_i[8:0];
      else if (cfg_idx_i == REG_LAYERS) layers_q <= cfg_dat_i[2:0];
      else lvl_q[cfg_idx_i] <= cfg_dat_i;
    end
  end

  dfls_front u_front (
    .clk_i, .rst_ni, .start, .busy, .in_i, .levels_i(levels_q),
    .pop_i(pop), .job_valid_o(jv), .job_o(job)
  );

  dfls_back u_back (
    .clk_i, .rst_ni, .job_valid_i(jv), .job_i(job), .pop_o(pop),
    .lvl_i(lvl_q), .layers_i(layers_q), .res_valid_o, .res_o
  );
endmodule
